// ===== src/assert_macros.svh =====
// Assertion macros included by the tag engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== src/hlbc_pkg.sv =====
//------------------------------------------------------------------------------
// hlbc_pkg
// Shared types and constants of the hashed LRU block cache tag engine.
//------------------------------------------------------------------------------
`default_nettype none
package hlbc_pkg;
    localparam int ENTRIES_DEF   = 32;
    localparam int BUCKETS_DEF   = 13;
    localparam int COUNT_MAX_DEF = 255;

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;
endpackage
`default_nettype wire

// ===== src/hlbc_ram.sv =====
//------------------------------------------------------------------------------
// hlbc_ram
// Generic single-port RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module hlbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== src/hashed_lru_block_cache_tags_core.sv =====
//------------------------------------------------------------------------------
// hashed_lru_block_cache_tags_core
// Tag, reference count and LRU engine of a hashed block buffer cache.
//------------------------------------------------------------------------------
// Release, pin and unpin pass the apply and output states, and the MRU state
// too when a release moves the entry to most recent. A get forms the bucket
// hash (quotient, then remainder), scans all entries for a matching tag and,
// on a miss, scans again for a free entry, passing the MRU state when the entry
// changes bucket. The next transaction is taken in the strobe cycle at the
// earliest; the receiver cannot stall. Tag words read as zero until written.
`default_nettype none
`include "assert_macros.svh"
module hashed_lru_block_cache_tags_core
    import hlbc_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int COUNT_MAX = COUNT_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] device_id,
    input  wire logic [31:0] block_number,
    input  wire logic [4:0]  entry_index,
    output logic             done,
    output logic [4:0]       entry_index_out,
    output logic             hit,
    output logic             need_read,
    output logic [1:0]       status
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW = IW;
    localparam int SW = IW + 1;

    // Reciprocal of BUCKETS: floor(x * MOD_MAGIC / 2^MOD_SHIFT) equals
    // floor(x / BUCKETS) for every 32-bit x.
    localparam int         MOD_SHIFT = 32 + $clog2(BUCKETS);
    localparam logic [32:0] MOD_MAGIC =
        33'(((64'd1 << MOD_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_MRU   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_QUO   = 3'd7;

    // Per-entry policy state (small, kept in flip-flops).
    logic [CW-1:0] cnt_reg  [ENTRIES];
    logic          vld_reg  [ENTRIES];
    logic [BW-1:0] bkt_reg  [ENTRIES];
    logic [RW-1:0] rank_reg [ENTRIES];
    logic          tagd_reg [ENTRIES]; // tags written since reset

    logic [2:0]  state_reg;
    logic [1:0]  op_reg;
    logic [31:0] dev_reg, blk_reg, rem_reg, quo_reg;
    logic [4:0]  idx_reg;
    logic [SW-1:0] ptr_reg;
    logic          fnd_reg;
    logic [IW-1:0] best_reg;
    logic [RW-1:0] brank_reg;
    logic [BW:0]   bdist_reg;
    logic          pend_reg;
    logic [IW-1:0] pidx_reg;
    logic [1:0]    st_reg;
    logic          hit_reg, nr_reg;
    logic [IW-1:0] ent_reg;
    logic [RW-1:0] old_reg;

    // Tag RAM: one word of device and block per entry.
    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [63:0]   ram_rd;
    hlbc_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_tags (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata({dev_reg, blk_reg}), .rdata(ram_rd)
    );

    wire [IW-1:0] ptr_i = ptr_reg[IW-1:0];
    wire [IW-1:0] idx_i = IW'(idx_reg);
    wire [BW-1:0] bk    = rem_reg[BW-1:0];

    // A tag word that was never written holds zero.
    wire [63:0] tag_rd = tagd_reg[pidx_reg] ? ram_rd : 64'd0;

    // Quotient product of the bucket hash.
    wire [71:0] mod_prod = {39'd0, MOD_MAGIC} * {40'd0, blk_reg};

    // Bucket distance of the scanned entry from the request's bucket.
    logic [BW:0] bkt_gap;
    always_comb
    begin
        if ({1'b0, bkt_reg[ptr_i]} >= {1'b0, bk})
            bkt_gap = {1'b0, bkt_reg[ptr_i]} - {1'b0, bk};
        else
            bkt_gap = {1'b0, bkt_reg[ptr_i]} + (BW+1)'(BUCKETS) - {1'b0, bk};
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done <= 1'b0;
            entry_index_out <= '0;
            hit <= 1'b0;
            need_read <= 1'b0;
            status <= ST_OK;
            op_reg <= OP_GET;
            dev_reg <= '0;
            blk_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            idx_reg <= '0;
            ptr_reg <= '0;
            fnd_reg <= 1'b0;
            best_reg <= '0;
            brank_reg <= '0;
            bdist_reg <= '0;
            pend_reg <= 1'b0;
            pidx_reg <= '0;
            st_reg <= ST_OK;
            hit_reg <= 1'b0;
            nr_reg <= 1'b0;
            ent_reg <= '0;
            old_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                cnt_reg[i]  <= '0;
                vld_reg[i]  <= 1'b0;
                bkt_reg[i]  <= '0;
                rank_reg[i] <= RW'(ENTRIES - 1 - i);
                tagd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= op; dev_reg <= device_id; blk_reg <= block_number;
                        idx_reg <= entry_index;
                        hit_reg <= 1'b0; nr_reg <= 1'b0; st_reg <= ST_OK;
                        fnd_reg <= 1'b0; ptr_reg <= '0; pend_reg <= 1'b0;
                        state_reg <= (op == OP_GET) ? S_MOD : S_APPLY;
                    end
                end
                S_MOD:
                begin
                    // Quotient by reciprocal multiplication.
                    quo_reg <= mod_prod[MOD_SHIFT +: 32];
                    state_reg <= S_QUO;
                end
                S_QUO:
                begin
                    rem_reg <= blk_reg - quo_reg * 32'(BUCKETS);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // RAM read data belongs to the previous pointer value, held in pidx_reg.
                    if (pend_reg &&
                        bkt_reg[pidx_reg] == bk && tag_rd == {dev_reg, blk_reg} &&
                        (!fnd_reg || rank_reg[pidx_reg] < brank_reg))
                    begin
                        fnd_reg <= 1'b1; best_reg <= pidx_reg;
                        brank_reg <= rank_reg[pidx_reg];
                    end
                    pidx_reg <= ptr_i;
                    if (ptr_reg == SW'(ENTRIES))
                    begin
                        pend_reg <= 1'b0;
                        ptr_reg <= '0;
                        state_reg <= S_FREE;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        ptr_reg <= ptr_reg + SW'(1);
                    end
                end
                S_FREE:
                begin
                    if (fnd_reg && !pend_reg)
                    begin
                        hit_reg <= 1'b1;
                        state_reg <= S_APPLY;
                    end
                    else if (ptr_reg == SW'(ENTRIES))
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        if (cnt_reg[ptr_i] == '0 &&
                            (!fnd_reg || bkt_gap < bdist_reg ||
                             (bkt_gap == bdist_reg && rank_reg[ptr_i] > brank_reg)))
                        begin
                            fnd_reg <= 1'b1; best_reg <= ptr_i;
                            bdist_reg <= bkt_gap; brank_reg <= rank_reg[ptr_i];
                        end
                        ptr_reg <= ptr_reg + SW'(1);
                    end
                end
                S_APPLY:
                begin
                    state_reg <= S_OUT;
                    if (op_reg == OP_GET)
                    begin
                        ent_reg <= best_reg;
                        if (!fnd_reg)
                        begin
                            st_reg <= ST_NOFREE; ent_reg <= '0;
                        end
                        else
                        begin
                            nr_reg <= !vld_reg[best_reg];
                            vld_reg[best_reg] <= 1'b1;
                            if (hit_reg)
                            begin
                                if (cnt_reg[best_reg] >= CW'(COUNT_MAX))
                                    st_reg <= ST_SAT;
                                else
                                    cnt_reg[best_reg] <= cnt_reg[best_reg] + CW'(1);
                            end
                            else
                            begin
                                nr_reg <= 1'b1;
                                cnt_reg[best_reg] <= CW'(1);
                                tagd_reg[best_reg] <= 1'b1;
                                if (bkt_reg[best_reg] != bk)
                                begin
                                    bkt_reg[best_reg] <= bk;
                                    old_reg <= rank_reg[best_reg];
                                    state_reg <= S_MRU;
                                end
                            end
                        end
                    end
                    else
                    begin
                        ent_reg <= idx_i;
                        if (32'(idx_reg) >= 32'(ENTRIES))
                            st_reg <= ST_NOFREE;
                        else if (op_reg == OP_PIN)
                        begin
                            if (cnt_reg[idx_i] >= CW'(COUNT_MAX))
                                st_reg <= ST_SAT;
                            else
                                cnt_reg[idx_i] <= cnt_reg[idx_i] + CW'(1);
                        end
                        else if (cnt_reg[idx_i] == '0)
                            st_reg <= ST_UNDER;
                        else
                        begin
                            cnt_reg[idx_i] <= cnt_reg[idx_i] - CW'(1);
                            if (op_reg == OP_RELEASE && cnt_reg[idx_i] == CW'(1))
                            begin
                                best_reg <= idx_i;
                                old_reg <= rank_reg[idx_i];
                                state_reg <= S_MRU;
                            end
                        end
                    end
                end
                S_MRU:
                begin
                    // Every entry compares its own rank in parallel.
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (IW'(i) == best_reg)
                            rank_reg[i] <= '0;
                        else if (rank_reg[i] < old_reg)
                            rank_reg[i] <= rank_reg[i] + RW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done <= 1'b1;
                    entry_index_out <= (op_reg == OP_GET) ? 5'(ent_reg) : idx_reg;
                    hit <= hit_reg; need_read <= nr_reg; status <= st_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ram_we   = (state_reg == S_APPLY) && (op_reg == OP_GET) && fnd_reg && !hit_reg;
    assign ram_addr = (state_reg == S_APPLY) ? best_reg : ptr_i;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy, "strobe while busy")
    `ASSERT_IMPLY(a_hit_get, clk, rst_n, done && hit, status != ST_NOFREE && status != ST_UNDER,
        "bad hit status")
endmodule
`default_nettype wire
